/* sv/vrpl_pkg.sv */
// ----------------------------------------------------------------------------
// vrpl_pkg
// Shared types and constants of the volume ramp and peak limiter.
// ----------------------------------------------------------------------------
package vrpl_pkg;

  localparam int CHANNELS  = 2;
  localparam int MAX_BLOCK = 4096;
  localparam int LANES     = 2;
  localparam int CH_USED   = (CHANNELS < 1) ? 1 : ((CHANNELS > LANES) ? LANES : CHANNELS);

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 31;
  localparam int MAG_W    = 25;
  localparam int ENV_W    = 17;
  localparam int NUM_W    = 31;
  localparam int ITER_W   = 5;

  localparam logic [ITER_W-1:0] DIV_STEP_ITERS = ITER_W'(31);
  localparam logic [ITER_W-1:0] DIV_LIM_ITERS  = ITER_W'(16);

  localparam logic [GAIN_W-1:0] RAMP_UNITY = GAIN_W'(16384 << 15);
  localparam logic [GAIN_W-1:0] RAMP_MAX   = GAIN_W'(65535 << 15);
  localparam logic [ENV_W-1:0]  ENV_ONE    = ENV_W'(65536);
  localparam logic [12:0]       BLOCK_MAX  = 13'(MAX_BLOCK);

  typedef enum logic [1:0] {
    REG_CEILING = 2'd0,
    REG_ATTACK  = 2'd1,
    REG_RELEASE = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_STEP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MAG,
    ST_PEAK,
    ST_DIV_LIM,
    ST_ENV,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic mag;
    logic scale;
  } lane_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  rem;
    logic [NUM_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic [ITER_W-1:0] iters;
  } div_req_t;

endpackage

/* sv/volume_ramp_peak_limiter_unit.sv */
// ----------------------------------------------------------------------------
// volume_ramp_peak_limiter_unit
// Stereo volume ramp followed by a feedforward peak limiter.
// ----------------------------------------------------------------------------
// One request on the input channel carries a stereo frame plus the block
// volume, block length and block start flag. Each request yields exactly one
// result request with the limited samples and the envelope gain.
// Configuration registers (ceiling, attack, release) are written through the
// cfg port with cfg_we, cfg_index and cfg_data. The user must write them
// only while idle; the block does not enforce it. An accepted frame runs
// through the states MUL_LO, MUL_HI, MAG, PEAK, ENV, SCALE and OUT to the
// output register; the ceiling/peak division runs between PEAK and ENV when
// the frame is limited, and a frame that starts a block first runs the ramp
// step division. Both divisions share one divider that produces one quotient
// bit per cycle, and frames are processed one at a time.
// The next input is taken as soon as the result sits in the output register,
// even if the receiver still stalls it; a stalled result holds until taken.
// Reset restores unity volume, zero ramp step, unity envelope and the
// register defaults.
// ----------------------------------------------------------------------------
module volume_ramp_peak_limiter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_sample_left,
  input  logic signed [23:0] in_sample_right,
  input  logic [15:0]        in_volume_gain,
  input  logic [12:0]        in_block_length,
  input  logic               in_block_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_left,
  output logic signed [23:0] out_right,
  output logic [16:0]        out_limiter_gain,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  vrpl_pkg::state_t state_r, state_nxt;

  logic [15:0] ceiling_r;
  logic [15:0] attack_r;
  logic [15:0] release_r;
  logic [15:0] prev_vol_r;
  logic [vrpl_pkg::GAIN_W-1:0] ramp_gain_r;
  logic signed [31:0]          ramp_step_r;
  logic [vrpl_pkg::ENV_W-1:0]  env_r;
  logic [vrpl_pkg::ENV_W-1:0]  target_r;
  logic                        diff_neg_r;
  logic                        out_valid_r;
  logic signed [23:0]          out_left_r;
  logic signed [23:0]          out_right_r;
  logic [16:0]                 out_gain_r;

  logic                        accept;
  logic                        load_out;
  vrpl_pkg::lane_ctrl_t        lane_ctrl;
  vrpl_pkg::div_req_t          div_req;
  logic                        div_done;
  logic [vrpl_pkg::NUM_W-1:0]  div_quot;

  logic [12:0]                 blk_len;
  logic signed [16:0]          vdiff;
  logic [15:0]                 vdiff_mag;
  logic [vrpl_pkg::MAG_W-1:0]  ceil_lvl;
  logic [vrpl_pkg::MAG_W-1:0]  peak;
  logic                        limit;
  logic signed [32:0]          ramp_sum;
  logic [vrpl_pkg::GAIN_W-1:0] ramp_clamped;
  logic signed [31:0]          step_val;
  logic [vrpl_pkg::ENV_W-1:0]  env_d;
  logic [32:0]                 env_prod;
  logic [vrpl_pkg::ENV_W-1:0]  env_nxt;

  logic signed [23:0]          lane_sample [vrpl_pkg::LANES];
  logic [vrpl_pkg::MAG_W-1:0]  lane_mag    [vrpl_pkg::LANES];
  logic signed [23:0]          lane_res    [vrpl_pkg::LANES];

  assign lane_sample[0] = in_sample_left;
  assign lane_sample[1] = in_sample_right;

  for (genvar c = 0; c < vrpl_pkg::LANES; c++) begin : g_lane
    vrpl_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .sample (lane_sample[c]),
      .gain   (ramp_gain_r),
      .env    (env_r),
      .mag    (lane_mag[c]),
      .result (lane_res[c])
    );
  end

  vrpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    if (in_block_length == 13'd0) begin
      blk_len = 13'd1;
    end else if (in_block_length > vrpl_pkg::BLOCK_MAX) begin
      blk_len = vrpl_pkg::BLOCK_MAX;
    end else begin
      blk_len = in_block_length;
    end
    vdiff     = $signed({1'b0, in_volume_gain}) - $signed({1'b0, prev_vol_r});
    vdiff_mag = vdiff[16] ? 16'(-vdiff) : vdiff[15:0];

    ceil_lvl = {ceiling_r, 9'b0};
    peak     = '0;
    for (int c = 0; c < vrpl_pkg::CH_USED; c++) begin
      if (lane_mag[c] > peak) begin
        peak = lane_mag[c];
      end
    end
    limit = (peak > ceil_lvl);

    ramp_sum = $signed({2'b00, ramp_gain_r}) + $signed({ramp_step_r[31], ramp_step_r});
    if (ramp_sum < 0) begin
      ramp_clamped = '0;
    end else if (ramp_sum > $signed({2'b00, vrpl_pkg::RAMP_MAX})) begin
      ramp_clamped = vrpl_pkg::RAMP_MAX;
    end else begin
      ramp_clamped = ramp_sum[vrpl_pkg::GAIN_W-1:0];
    end
    step_val = diff_neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    if (target_r < env_r) begin
      env_d    = env_r - target_r;
      env_prod = 33'(env_d) * 33'(attack_r);
      env_nxt  = target_r + env_prod[32:16];
    end else begin
      env_d    = target_r - env_r;
      env_prod = 33'(env_d) * 33'(release_r);
      env_nxt  = target_r - env_prod[32:16];
    end
  end

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    load_out  = 1'b0;
    lane_ctrl = '0;
    div_req   = '0;
    in_stall  = (state_r != vrpl_pkg::ST_IDLE);
    unique case (state_r)
      vrpl_pkg::ST_IDLE: begin
        if (in_valid) begin
          accept         = 1'b1;
          lane_ctrl.load = 1'b1;
          if (in_block_start) begin
            div_req.start = 1'b1;
            div_req.rem   = '0;
            div_req.num   = {vdiff_mag, 15'b0};
            div_req.den   = vrpl_pkg::MAG_W'(blk_len);
            div_req.iters = vrpl_pkg::DIV_STEP_ITERS;
            state_nxt     = vrpl_pkg::ST_DIV_STEP;
          end else begin
            state_nxt = vrpl_pkg::ST_MUL_LO;
          end
        end
      end
      vrpl_pkg::ST_DIV_STEP: begin
        if (div_done) begin
          state_nxt = vrpl_pkg::ST_MUL_LO;
        end
      end
      vrpl_pkg::ST_MUL_LO: begin
        lane_ctrl.mul_lo = 1'b1;
        state_nxt        = vrpl_pkg::ST_MUL_HI;
      end
      vrpl_pkg::ST_MUL_HI: begin
        lane_ctrl.mul_hi = 1'b1;
        state_nxt        = vrpl_pkg::ST_MAG;
      end
      vrpl_pkg::ST_MAG: begin
        lane_ctrl.mag = 1'b1;
        state_nxt     = vrpl_pkg::ST_PEAK;
      end
      vrpl_pkg::ST_PEAK: begin
        if (limit) begin
          div_req.start = 1'b1;
          div_req.rem   = ceil_lvl;
          div_req.num   = '0;
          div_req.den   = peak;
          div_req.iters = vrpl_pkg::DIV_LIM_ITERS;
          state_nxt     = vrpl_pkg::ST_DIV_LIM;
        end else begin
          state_nxt = vrpl_pkg::ST_ENV;
        end
      end
      vrpl_pkg::ST_DIV_LIM: begin
        if (div_done) begin
          state_nxt = vrpl_pkg::ST_ENV;
        end
      end
      vrpl_pkg::ST_ENV: begin
        state_nxt = vrpl_pkg::ST_SCALE;
      end
      vrpl_pkg::ST_SCALE: begin
        lane_ctrl.scale = 1'b1;
        state_nxt       = vrpl_pkg::ST_OUT;
      end
      vrpl_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = vrpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vrpl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrpl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r   <= 16'd16384;
      attack_r    <= 16'd65535;
      release_r   <= 16'd65535;
      prev_vol_r  <= 16'd16384;
      ramp_gain_r <= vrpl_pkg::RAMP_UNITY;
      ramp_step_r <= '0;
      env_r       <= vrpl_pkg::ENV_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vrpl_pkg::REG_CEILING: ceiling_r <= cfg_data;
          vrpl_pkg::REG_ATTACK:  attack_r  <= cfg_data;
          vrpl_pkg::REG_RELEASE: release_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept && in_block_start) begin
        prev_vol_r  <= in_volume_gain;
        ramp_gain_r <= {prev_vol_r, 15'b0};
      end
      if (state_r == vrpl_pkg::ST_DIV_STEP && div_done) begin
        ramp_step_r <= step_val;
      end
      if (state_r == vrpl_pkg::ST_MAG) begin
        ramp_gain_r <= ramp_clamped;
      end
      if (state_r == vrpl_pkg::ST_ENV) begin
        env_r <= (env_nxt > vrpl_pkg::ENV_ONE) ? vrpl_pkg::ENV_ONE : env_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_neg_r <= vdiff[16];
    end
    if (state_r == vrpl_pkg::ST_PEAK) begin
      target_r <= vrpl_pkg::ENV_ONE;
    end
    if (state_r == vrpl_pkg::ST_DIV_LIM && div_done) begin
      target_r <= {1'b0, div_quot[15:0]};
    end
    if (load_out) begin
      out_left_r  <= (vrpl_pkg::CH_USED > 0) ? lane_res[0] : '0;
      out_right_r <= (vrpl_pkg::CH_USED > 1) ? lane_res[1] : '0;
      out_gain_r  <= env_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left         = out_left_r;
  assign out_right        = out_right_r;
  assign out_limiter_gain = out_gain_r;

endmodule

/* sv/vrpl_lane.sv */
// ----------------------------------------------------------------------------
// vrpl_lane
// One channel: ramp gain scaling, magnitude, envelope scaling, saturation.
// ----------------------------------------------------------------------------
module vrpl_lane (
  input  logic                                clk,
  input  vrpl_pkg::lane_ctrl_t                ctrl,
  input  logic signed [vrpl_pkg::SAMPLE_W-1:0] sample,
  input  logic [vrpl_pkg::GAIN_W-1:0]         gain,
  input  logic [vrpl_pkg::ENV_W-1:0]          env,
  output logic [vrpl_pkg::MAG_W-1:0]          mag,
  output logic signed [vrpl_pkg::SAMPLE_W-1:0] result
);

  logic        neg_r;
  logic [23:0] abs_r;
  logic [38:0] plo_r;
  logic [39:0] phi_r;
  logic [24:0] mag_r;
  logic [41:0] sp_r;

  logic [23:0] raw;
  logic [23:0] abs_nxt;
  logic [55:0] mag_sum;
  logic [42:0] sp_sum;
  logic [26:0] scaled;

  always_comb begin
    raw     = sample;
    abs_nxt = raw[23] ? (~raw + 24'd1) : raw;
    mag_sum = 56'({phi_r, 15'b0}) + 56'(plo_r) + (56'd1 << 28);
    sp_sum  = 43'(sp_r) + 43'd32768;
    scaled  = sp_sum[42:16];
    if (neg_r) begin
      if (scaled > 27'd8388608) begin
        result = -24'sd8388608;
      end else begin
        result = $signed(24'd0 - scaled[23:0]);
      end
    end else begin
      if (scaled > 27'd8388607) begin
        result = 24'sd8388607;
      end else begin
        result = $signed(scaled[23:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg_r <= raw[23];
      abs_r <= abs_nxt;
    end
    if (ctrl.mul_lo) begin
      plo_r <= 39'(abs_r) * 39'(gain[14:0]);
    end
    if (ctrl.mul_hi) begin
      phi_r <= 40'(abs_r) * 40'(gain[30:15]);
    end
    if (ctrl.mag) begin
      mag_r <= mag_sum[53:29];
    end
    if (ctrl.scale) begin
      sp_r <= 42'(mag_r) * 42'(env);
    end
  end

  assign mag = mag_r;

endmodule

/* sv/vrpl_div.sv */
// ----------------------------------------------------------------------------
// vrpl_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrpl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vrpl_pkg::div_req_t          req,
  output logic                        done,
  output logic [vrpl_pkg::NUM_W-1:0]  quot
);

  logic [vrpl_pkg::ITER_W-1:0] cnt_r;
  logic [vrpl_pkg::MAG_W-1:0]  rem_r;
  logic [vrpl_pkg::NUM_W-1:0]  num_r;
  logic [vrpl_pkg::MAG_W-1:0]  den_r;
  logic                        done_r;

  logic [vrpl_pkg::MAG_W:0]    trial;
  logic                        ge;

  always_comb begin
    trial = {rem_r, num_r[vrpl_pkg::NUM_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= req.iters;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == vrpl_pkg::ITER_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - vrpl_pkg::ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem;
      num_r <= req.num;
      den_r <= req.den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? vrpl_pkg::MAG_W'(trial - {1'b0, den_r}) : trial[vrpl_pkg::MAG_W-1:0];
      num_r <= {num_r[vrpl_pkg::NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule
